/* src/htw_pkg.sv */
// htw_pkg: shared types and constants of the timer wheel
// no dependencies
`timescale 1ns / 1ps
package htw_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = 7;
  localparam int Q_DEPTH    = 2;
  localparam int QP_W       = $clog2(Q_DEPTH);
  localparam int QC_W       = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRE   = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] delay;
    logic [31:0] cancel_id;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [31:0]      result_id;
    logic             ok;
    logic [CNT_W-1:0] active_count;
    logic             last;
  } result_t;

  typedef struct packed {
    logic valid;
    cmd_t job;
  } qhead_t;

endpackage

/* src/htw_front.sv */
// htw_front: takes commands, drops OP_NONE commands, queues the rest
// depends on htw_pkg
`timescale 1ns / 1ps
module htw_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  htw_pkg::cmd_t   cmd,
  output htw_pkg::qhead_t head,
  input  logic            pop
);

  htw_pkg::cmd_t                q_mem [htw_pkg::Q_DEPTH];
  logic [htw_pkg::QP_W-1:0]     wr_ptr;
  logic [htw_pkg::QP_W-1:0]     rd_ptr;
  logic [htw_pkg::QC_W-1:0]     q_cnt;
  logic                         push;
  logic                         do_pop;

  assign busy   = (q_cnt == htw_pkg::QC_W'(htw_pkg::Q_DEPTH));
  assign push   = start && !busy && (cmd.op != htw_pkg::OP_NONE);
  assign do_pop = pop && (q_cnt != '0);

  assign head.valid = (q_cnt != '0);
  assign head.job   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        q_cnt <= q_cnt + 1'b1;
      end else if (!push && do_pop) begin
        q_cnt <= q_cnt - 1'b1;
      end
    end
  end

endmodule

/* src/htw_back.sv */
// htw_back: executes add, cancel and tick jobs by sweeping the timer pool
// depends on htw_pkg
`timescale 1ns / 1ps
module htw_back (
  input  logic              clk,
  input  logic              rst,
  input  htw_pkg::qhead_t   head,
  output logic              pop,
  output logic              strobe,
  output htw_pkg::result_t  result
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_C_RD, S_C_CMP, S_T_RD, S_T_CMP, S_T_EVAL,
    S_F_RD, S_F_CMP, S_F_EMIT
  } state_t;

  localparam logic [htw_pkg::IDX_W-1:0] IDX_LAST = htw_pkg::IDX_W'(htw_pkg::POOL_DEPTH - 1);

  state_t                        state;
  htw_pkg::cmd_t                 job;
  logic [htw_pkg::IDX_W-1:0]     idx;
  logic [63:0]                   tick_now;
  logic [31:0]                   next_id;
  logic [htw_pkg::CNT_W-1:0]     live_count;
  logic [htw_pkg::CNT_W-1:0]     due_n;
  logic [htw_pkg::POOL_DEPTH-1:0] slot_valid;
  logic [htw_pkg::POOL_DEPTH-1:0] slot_canceled;
  logic [htw_pkg::POOL_DEPTH-1:0] due;
  logic                          have_best;
  logic [31:0]                   best_id;
  logic [htw_pkg::IDX_W-1:0]     best_idx;

  logic [31:0]                   id_mem  [htw_pkg::POOL_DEPTH];
  logic [63:0]                   exp_mem [htw_pkg::POOL_DEPTH];
  logic [31:0]                   id_q;
  logic [63:0]                   exp_q;
  logic                          mem_we;
  logic [31:0]                   next_id_inc;

  assign pop         = (state == S_IDLE) && head.valid;
  assign mem_we      = (state == S_ADD) && !slot_valid[idx];
  assign next_id_inc = next_id + 32'd1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[idx]  <= next_id;
      exp_mem[idx] <= tick_now + {32'd0, job.delay};
    end
    id_q  <= id_mem[idx];
    exp_q <= exp_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      idx           <= '0;
      tick_now      <= '0;
      next_id       <= 32'd1;
      live_count    <= '0;
      due_n         <= '0;
      slot_valid    <= '0;
      slot_canceled <= '0;
      due           <= '0;
      have_best     <= 1'b0;
      strobe        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            job <= head.job;
            idx <= '0;
            case (head.job.op)
              htw_pkg::OP_ADD:    state <= S_ADD;
              htw_pkg::OP_CANCEL: state <= S_C_RD;
              htw_pkg::OP_TICK:   state <= S_T_RD;
              default:            state <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (!slot_valid[idx]) begin
            slot_valid[idx]     <= 1'b1;
            slot_canceled[idx]  <= 1'b0;
            next_id             <= (next_id_inc == '0) ? 32'd1 : next_id_inc;
            live_count          <= live_count + 1'b1;
            strobe              <= 1'b1;
            result.kind         <= htw_pkg::KIND_ADD;
            result.result_id    <= next_id;
            result.ok           <= 1'b1;
            result.active_count <= live_count + 1'b1;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end else if (idx == IDX_LAST) begin
            strobe              <= 1'b1;
            result.kind         <= htw_pkg::KIND_ADD;
            result.result_id    <= '0;
            result.ok           <= 1'b0;
            result.active_count <= live_count;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_C_RD: state <= S_C_CMP;
        S_C_CMP: begin
          if (slot_valid[idx] && !slot_canceled[idx] && id_q == job.cancel_id) begin
            slot_canceled[idx]  <= 1'b1;
            live_count          <= (live_count != '0) ? live_count - 1'b1 : live_count;
            strobe              <= 1'b1;
            result.kind         <= htw_pkg::KIND_CANCEL;
            result.result_id    <= '0;
            result.ok           <= 1'b1;
            result.active_count <= (live_count != '0) ? live_count - 1'b1 : live_count;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end else if (idx == IDX_LAST) begin
            strobe              <= 1'b1;
            result.kind         <= htw_pkg::KIND_CANCEL;
            result.result_id    <= '0;
            result.ok           <= 1'b0;
            result.active_count <= live_count;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_C_RD;
          end
        end
        S_T_RD: state <= S_T_CMP;
        S_T_CMP: begin
          if (slot_valid[idx] && exp_q == tick_now) begin
            if (slot_canceled[idx]) begin
              slot_valid[idx] <= 1'b0;
            end else begin
              due[idx] <= 1'b1;
              due_n    <= due_n + 1'b1;
            end
          end
          if (idx == IDX_LAST) begin
            state <= S_T_EVAL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_T_RD;
          end
        end
        S_T_EVAL: begin
          tick_now <= tick_now + 64'd1;
          if (due_n == '0) begin
            strobe              <= 1'b1;
            result.kind         <= htw_pkg::KIND_DONE;
            result.result_id    <= '0;
            result.ok           <= 1'b1;
            result.active_count <= live_count;
            result.last         <= 1'b1;
            state               <= S_IDLE;
          end else begin
            idx       <= '0;
            have_best <= 1'b0;
            state     <= S_F_RD;
          end
        end
        S_F_RD: state <= S_F_CMP;
        S_F_CMP: begin
          if (due[idx] && (!have_best || id_q < best_id)) begin
            have_best <= 1'b1;
            best_id   <= id_q;
            best_idx  <= idx;
          end
          if (idx == IDX_LAST) begin
            state <= S_F_EMIT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_F_RD;
          end
        end
        S_F_EMIT: begin
          slot_valid[best_idx] <= 1'b0;
          due[best_idx]        <= 1'b0;
          due_n                <= due_n - 1'b1;
          live_count           <= (live_count != '0) ? live_count - 1'b1 : live_count;
          strobe               <= 1'b1;
          result.kind          <= htw_pkg::KIND_FIRE;
          result.result_id     <= best_id;
          result.ok            <= 1'b1;
          result.active_count  <= (live_count != '0) ? live_count - 1'b1 : live_count;
          result.last          <= (due_n == htw_pkg::CNT_W'(1));
          if (due_n == htw_pkg::CNT_W'(1)) begin
            state <= S_IDLE;
          end else begin
            idx       <= '0;
            have_best <= 1'b0;
            state     <= S_F_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_due_count: assert property (@(posedge clk) disable iff (rst)
    due_n == htw_pkg::CNT_W'($countones(due)))
    else $error("due count out of step with due flags");

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= htw_pkg::CNT_W'($countones(slot_valid)))
    else $error("live count exceeds occupied slots");

  a_fire_chain: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |-> state == S_F_RD)
    else $error("non-final fire not followed by another search");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> due == '0)
    else $error("pending fires left behind");

endmodule

/* src/hierarchical_timer_wheel_unit.sv */
// hierarchical_timer_wheel_unit: top level of the one-shot timer pool
// depends on htw_pkg, htw_front, htw_back
//
// channel   dir  handshake               payload
// command   in   start && !busy           cmd    (htw_pkg::cmd_t)
// result    out  strobe, one cycle each   result (htw_pkg::result_t)
//
// add: one slot of the valid flags checked per cycle, first free slot taken
// cancel: slots swept in turn (read, then compare), id memory read port, early stop on match
// tick: one full sweep marks due timers, then one full search sweep per fired timer, lowest id first
// a two-entry queue holds commands while a job runs, busy only when it is full; results cannot stall
// rst is synchronous; pool empty, tick count zero, first id is one
`timescale 1ns / 1ps
module hierarchical_timer_wheel_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  htw_pkg::cmd_t     cmd,
  output logic              strobe,
  output htw_pkg::result_t  result
);

  htw_pkg::qhead_t head;
  logic            pop;

  htw_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .head  (head),
    .pop   (pop)
  );

  htw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

/* bench/hierarchical_timer_wheel_unit_test.sv */
// hierarchical_timer_wheel_unit_test: self-checking bench for the timer pool
// drives add, cancel and tick commands and checks every result transfer
// depends on htw_pkg and hierarchical_timer_wheel_unit
`timescale 1ns / 1ps
module hierarchical_timer_wheel_unit_test;

  localparam int LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  htw_pkg::cmd_t cmd = '0;
  logic strobe;
  htw_pkg::result_t result;

  hierarchical_timer_wheel_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .strobe(strobe), .result(result)
  );

  always #4 clk = ~clk;

  // timer pool shadow
  logic [63:0] tick_now;
  logic [31:0] next_id;
  logic        sv_valid [htw_pkg::POOL_DEPTH];
  logic        sv_cancel [htw_pkg::POOL_DEPTH];
  logic [31:0] sv_id [htw_pkg::POOL_DEPTH];
  logic [63:0] sv_exp [htw_pkg::POOL_DEPTH];
  logic [htw_pkg::CNT_W-1:0] live;
  logic [31:0] issued [$];

  htw_pkg::result_t pending [$];
  int errors = 0;
  int results_seen = 0;
  int fires_seen = 0;
  int cycles = 0;

  task automatic report(input string what, input htw_pkg::result_t got,
                        input htw_pkg::result_t want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic htw_pkg::result_t mk(htw_pkg::kind_t k, logic [31:0] id, logic ok,
                                          logic lst);
    htw_pkg::result_t r;
    r.kind = k; r.result_id = id; r.ok = ok; r.active_count = live; r.last = lst;
    return r;
  endfunction

  function automatic void queue_result(input htw_pkg::result_t r);
    pending.insert(pending.size(), r);
  endfunction

  task automatic timer_pool_predict(input htw_pkg::cmd_t c);
    int i, n, best;
    logic due [htw_pkg::POOL_DEPTH];
    case (c.op)
      htw_pkg::OP_ADD: begin
        for (i = 0; i < htw_pkg::POOL_DEPTH; i++) if (!sv_valid[i]) break;
        if (i >= htw_pkg::POOL_DEPTH) begin
          queue_result(mk(htw_pkg::KIND_ADD, 32'd0, 1'b0, 1'b1));
        end else begin
          sv_valid[i] = 1'b1; sv_cancel[i] = 1'b0; sv_id[i] = next_id;
          sv_exp[i] = tick_now + {32'd0, c.delay};
          issued.insert(issued.size(), next_id);
          next_id = next_id + 1; if (next_id == 0) next_id = 1;
          live++;
          queue_result(mk(htw_pkg::KIND_ADD, sv_id[i], 1'b1, 1'b1));
        end
      end
      htw_pkg::OP_CANCEL: begin
        for (i = 0; i < htw_pkg::POOL_DEPTH; i++)
          if (sv_valid[i] && !sv_cancel[i] && sv_id[i] == c.cancel_id) break;
        if (i < htw_pkg::POOL_DEPTH) begin
          sv_cancel[i] = 1'b1; if (live > 0) live--;
          queue_result(mk(htw_pkg::KIND_CANCEL, 32'd0, 1'b1, 1'b1));
        end else queue_result(mk(htw_pkg::KIND_CANCEL, 32'd0, 1'b0, 1'b1));
      end
      htw_pkg::OP_TICK: begin
        n = 0;
        for (i = 0; i < htw_pkg::POOL_DEPTH; i++) begin
          due[i] = 1'b0;
          if (sv_valid[i] && sv_exp[i] == tick_now) begin
            if (sv_cancel[i]) sv_valid[i] = 1'b0;
            else begin due[i] = 1'b1; n++; end
          end
        end
        tick_now = tick_now + 1;
        if (n == 0) queue_result(mk(htw_pkg::KIND_DONE, 32'd0, 1'b1, 1'b1));
        for (int k = 0; k < n; k++) begin
          best = -1;
          for (i = 0; i < htw_pkg::POOL_DEPTH; i++)
            if (due[i] && (best < 0 || sv_id[i] < sv_id[best])) best = i;
          due[best] = 1'b0; sv_valid[best] = 1'b0; if (live > 0) live--;
          queue_result(mk(htw_pkg::KIND_FIRE, sv_id[best], 1'b1, k == n - 1));
        end
      end
      default: ;
    endcase
  endtask

  // result checking
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && strobe) begin
      results_seen <= results_seen + 1;
      if (result.kind == htw_pkg::KIND_FIRE) fires_seen <= fires_seen + 1;
      if (pending.size() == 0) report("unexpected", result, '0);
      else begin
        htw_pkg::result_t w;
        w = pending.pop_front();
        if (result.kind !== w.kind) report("kind", result, w);
        if (result.result_id !== w.result_id) report("result_id", result, w);
        if (result.ok !== w.ok) report("ok", result, w);
        if (result.active_count !== w.active_count) report("active_count", result, w);
        if (result.last !== w.last) report("last", result, w);
      end
    end
    if (cycles > LIMIT) begin
      $display("hierarchical_timer_wheel_unit verification failed");
      $finish;
    end
  end

  // start stays high across back-to-back transfers; it drops only for a gap
  task automatic send(input htw_pkg::cmd_t c, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      cmd <= {htw_pkg::OP_NONE, $urandom(), $urandom()};
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    timer_pool_predict(c);
    @(negedge clk);
  endtask

  function automatic htw_pkg::cmd_t mkcmd(htw_pkg::op_t o, logic [31:0] d, logic [31:0] t);
    htw_pkg::cmd_t c;
    c.op = o; c.delay = d; c.cancel_id = t;
    return c;
  endfunction

  typedef struct {
    htw_pkg::cmd_t    c;
    logic             typed;
    htw_pkg::result_t want;
  } row_t;

  row_t rows [$];
  htw_pkg::cmd_t c;
  int r, nofill;

  function automatic void add_row(input htw_pkg::cmd_t rc, input logic rtyped,
                                  input htw_pkg::result_t rwant);
    row_t row;
    row.c = rc; row.typed = rtyped; row.want = rwant;
    rows.insert(rows.size(), row);
  endfunction

  initial begin
    tick_now = 0; next_id = 1; live = 0;
    for (int i = 0; i < htw_pkg::POOL_DEPTH; i++) begin sv_valid[i] = 0; sv_cancel[i] = 0; end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    add_row(mkcmd(htw_pkg::OP_TICK, 0, 0), 1'b1,
            '{htw_pkg::KIND_DONE, 32'd0, 1'b1, 7'd0, 1'b1});
    add_row(mkcmd(htw_pkg::OP_CANCEL, 0, 1), 1'b1,
            '{htw_pkg::KIND_CANCEL, 32'd0, 1'b0, 7'd0, 1'b1});
    add_row(mkcmd(htw_pkg::OP_ADD, 0, 32'hffffffff), 1'b1,
            '{htw_pkg::KIND_ADD, 32'd1, 1'b1, 7'd1, 1'b1});
    add_row(mkcmd(htw_pkg::OP_ADD, 32'hffffffff, 0), 1'b1,
            '{htw_pkg::KIND_ADD, 32'd2, 1'b1, 7'd2, 1'b1});
    add_row(mkcmd(htw_pkg::OP_ADD, 0, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_CANCEL, 0, 3), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_CANCEL, 0, 3), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_NONE, 32'hffffffff, 32'hffffffff), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_TICK, 0, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_ADD, 1, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_ADD, 1, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_ADD, 2, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_TICK, 0, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_TICK, 0, 0), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_CANCEL, 0, 32'hffffffff), 1'b0, '0);
    add_row(mkcmd(htw_pkg::OP_TICK, 0, 0), 1'b0, '0);
    foreach (rows[i]) begin
      send(rows[i].c, $urandom_range(0, 11));
      if (rows[i].typed) begin
        void'(pending.pop_back());
        queue_result(rows[i].want);
      end
    end

    // fill the pool to exercise refusal, then drain with ticks
    for (int i = 0; i < htw_pkg::POOL_DEPTH + 2; i++)
      send(mkcmd(htw_pkg::OP_ADD, $urandom_range(0, 3), 0),
           (i % 3 == 0) ? $urandom_range(0, 11) : 0);
    repeat (5) send(mkcmd(htw_pkg::OP_TICK, 0, 0), $urandom_range(0, 11));
    send(mkcmd(htw_pkg::OP_ADD, 32'hffffffff, 0), 0);

    // random mix
    for (int n = 0; n < 82; n++) begin
      r = $urandom_range(0, 99);
      nofill = (n / 40) % 2;
      if (r < 40) c = mkcmd(htw_pkg::OP_ADD, ($urandom_range(0, 9) == 0) ? $urandom() :
                            $urandom_range(0, 6), $urandom());
      else if (r < 60 && issued.size() > 0)
        c = mkcmd(htw_pkg::OP_CANCEL, $urandom(), issued[$urandom_range(0, issued.size() - 1)]);
      else if (r < 65) c = mkcmd(htw_pkg::OP_CANCEL, $urandom(), $urandom());
      else if (r < 68) c = mkcmd(htw_pkg::OP_NONE, $urandom(), $urandom());
      else c = mkcmd(htw_pkg::OP_TICK, $urandom(), $urandom());
      send(c, nofill ? 0 : $urandom_range(0, 11));
    end
    start <= 1'b0;
    cmd <= {htw_pkg::OP_NONE, $urandom(), $urandom()};

    while (pending.size() != 0) @(posedge clk);
    repeat (4 * htw_pkg::POOL_DEPTH + 10) @(posedge clk);
    $display("covered %0d results including %0d fires, with pool-full refusal and bad cancels",
             results_seen, fires_seen);
    if (errors == 0) $display("hierarchical_timer_wheel_unit verification clean");
    else $display("hierarchical_timer_wheel_unit verification failed");
    $finish;
  end
endmodule
